[design/xcns_pkg.sv]
// Shared types and constants for the XOR closest-node selector.
`timescale 1ns / 1ps
package xcns_pkg;

  localparam int LIST_CAPACITY = 8;
  localparam int HANDLE_BITS   = 16;
  localparam int ID_HI_W       = 32;
  localparam int ID_MID_W      = 64;
  localparam int ID_LO_W       = 64;
  localparam int ID_BITS       = ID_HI_W + ID_MID_W + ID_LO_W;

  localparam int IDX_W  = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int CNT_W  = $clog2(LIST_CAPACITY + 1);
  localparam int RANK_W = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_HI  = 2'd0,
    CFG_TARGET_MID = 2'd1,
    CFG_TARGET_LO  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [ID_BITS-1:0]     id;
  } entry_t;

  typedef struct packed {
    logic load_cand;   // take the incoming candidate
    logic load_left;   // take the nearer neighbor's entry (insert shift)
    logic shift_out;   // take the farther neighbor's entry (drain shift)
  } cell_ctrl_t;

endpackage

[design/xcns_ifs.sv]
// Channel interfaces: candidate input, node result output, config write.
`timescale 1ns / 1ps
interface xcns_cand_if import xcns_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [HANDLE_BITS-1:0] cand_handle;
  logic [ID_HI_W-1:0]     cand_id_hi;
  logic [ID_MID_W-1:0]    cand_id_mid;
  logic [ID_LO_W-1:0]     cand_id_lo;
  logic                   last_candidate;

  modport source (output valid, cand_handle, cand_id_hi, cand_id_mid, cand_id_lo,
                  last_candidate, input ready);
  modport sink (input valid, cand_handle, cand_id_hi, cand_id_mid, cand_id_lo,
                last_candidate, output ready);
endinterface

interface xcns_node_if import xcns_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [HANDLE_BITS-1:0] node_handle;
  logic [ID_HI_W-1:0]     node_id_hi;
  logic [ID_MID_W-1:0]    node_id_mid;
  logic [ID_LO_W-1:0]     node_id_lo;
  logic [RANK_W-1:0]      rank;
  logic                   final_of_run;
  logic                   list_empty;

  modport source (output valid, node_handle, node_id_hi, node_id_mid, node_id_lo,
                  rank, final_of_run, list_empty, input ready);
  modport sink (input valid, node_handle, node_id_hi, node_id_mid, node_id_lo,
                rank, final_of_run, list_empty, output ready);
endinterface

interface xcns_cfg_if import xcns_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/xor_closest_node_selector_core.sv]
// Top level of the XOR closest-node selector: cell chain, control and output stage.
// Non-final candidates: one per cycle, the sorted insert completes in the accept cycle.
// Final candidate: the list drains nearest first out of cell 0, one result per cycle while
// the output register is free, each result registered in the output stage after the state
// enters drain; the next candidate is taken once the last or empty-list result is loaded.
// Synchronous active-low reset clears count, state, target and output valid; cells
// hold no reset and are only read below the count.
`timescale 1ns / 1ps
module xor_closest_node_selector_core import xcns_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  xcns_cand_if.sink  in_cand,
  xcns_node_if.source out_node,
  xcns_cfg_if.sink   cfg_wr
);

  typedef enum logic {ST_ACCEPT, ST_DRAIN} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic                 empty_r, empty_nxt;
  logic [IDX_W-1:0]     rank_r, rank_nxt;
  logic [ID_HI_W-1:0]   tgt_hi_r, tgt_hi_nxt;
  logic [ID_MID_W-1:0]  tgt_mid_r, tgt_mid_nxt;
  logic [ID_LO_W-1:0]   tgt_lo_r, tgt_lo_nxt;

  logic                 out_valid_r, out_valid_nxt;
  entry_t               out_ent_r, out_ent_nxt;
  logic [IDX_W-1:0]     out_rank_r, out_rank_nxt;
  logic                 out_final_r, out_final_nxt;
  logic                 out_empty_r, out_empty_nxt;

  entry_t               cand;
  logic [ID_BITS-1:0]   target;
  entry_t               cell_ent [LIST_CAPACITY];
  cell_ctrl_t           cell_ctrl [LIST_CAPACITY];
  logic [LIST_CAPACITY-1:0] id_eq, nearer, occ, ins_ok;

  logic in_fire, dup, do_ins, slot_free, drain_shift;
  logic [CNT_W-1:0] count_ins;

  assign cand.handle = in_cand.cand_handle;
  assign cand.id     = {in_cand.cand_id_hi, in_cand.cand_id_mid, in_cand.cand_id_lo};
  assign target      = {tgt_hi_r, tgt_mid_r, tgt_lo_r};

  assign in_cand.ready = (state_r == ST_ACCEPT);
  assign in_fire       = in_cand.valid && in_cand.ready;
  assign cfg_wr.ready  = 1'b1;
  assign slot_free     = !out_valid_r || out_node.ready;
  assign drain_shift   = (state_r == ST_DRAIN) && slot_free && !empty_r;

  // Insert point is the first slot that is empty or farther than the candidate;
  // distances in the list are strictly increasing, so ins_ok is a suffix.
  for (genvar i = 0; i < LIST_CAPACITY; i++) begin : g_cell
    assign occ[i]    = (CNT_W'(i) < count_r);
    assign ins_ok[i] = !occ[i] || nearer[i];

    if (i == 0) begin : g_first
      assign cell_ctrl[i].load_cand = do_ins && ins_ok[i];
      assign cell_ctrl[i].load_left = 1'b0;
    end else begin : g_rest
      assign cell_ctrl[i].load_cand = do_ins && ins_ok[i] && !ins_ok[i-1];
      assign cell_ctrl[i].load_left = do_ins && ins_ok[i-1];
    end
    assign cell_ctrl[i].shift_out = drain_shift;

    xcns_cell u_cell (
      .clk         (clk),
      .cand        (cand),
      .target      (target),
      .left_entry  ((i == 0) ? cand : cell_ent[(i == 0) ? 0 : i-1]),
      .right_entry ((i == LIST_CAPACITY-1) ? cand
                                           : cell_ent[(i == LIST_CAPACITY-1) ? i : i+1]),
      .ctrl        (cell_ctrl[i]),
      .entry       (cell_ent[i]),
      .id_equal    (id_eq[i]),
      .cand_nearer (nearer[i])
    );
  end

  assign dup       = |(id_eq & occ);
  assign do_ins    = in_fire && !dup && ins_ok[LIST_CAPACITY-1];
  assign count_ins = count_r + CNT_W'(do_ins && (count_r < CNT_W'(LIST_CAPACITY)));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    empty_nxt     = empty_r;
    rank_nxt      = rank_r;
    tgt_hi_nxt    = tgt_hi_r;
    tgt_mid_nxt   = tgt_mid_r;
    tgt_lo_nxt    = tgt_lo_r;
    out_valid_nxt = out_valid_r && !out_node.ready;
    out_ent_nxt   = out_ent_r;
    out_rank_nxt  = out_rank_r;
    out_final_nxt = out_final_r;
    out_empty_nxt = out_empty_r;

    if (cfg_wr.valid) begin
      unique case (cfg_idx_t'(cfg_wr.index))
        CFG_TARGET_HI:  tgt_hi_nxt  = cfg_wr.data[ID_HI_W-1:0];
        CFG_TARGET_MID: tgt_mid_nxt = cfg_wr.data[ID_MID_W-1:0];
        CFG_TARGET_LO:  tgt_lo_nxt  = cfg_wr.data[ID_LO_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_ACCEPT: begin
        if (in_fire) begin
          if (in_cand.last_candidate) begin
            count_nxt = '0;
            rem_nxt   = count_ins;
            empty_nxt = (count_ins == '0);
            rank_nxt  = '0;
            state_nxt = ST_DRAIN;
          end else begin
            count_nxt = count_ins;
          end
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (empty_r) begin
            out_ent_nxt   = '0;
            out_rank_nxt  = '0;
            out_final_nxt = 1'b1;
            out_empty_nxt = 1'b1;
            state_nxt     = ST_ACCEPT;
          end else begin
            out_ent_nxt   = cell_ent[0];
            out_rank_nxt  = rank_r;
            out_final_nxt = (rem_r == CNT_W'(1));
            out_empty_nxt = 1'b0;
            rank_nxt      = rank_r + IDX_W'(1);
            rem_nxt       = rem_r - CNT_W'(1);
            if (rem_r == CNT_W'(1)) begin
              state_nxt = ST_ACCEPT;
            end
          end
        end
      end
      default: state_nxt = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      count_r     <= '0;
      rem_r       <= '0;
      empty_r     <= 1'b0;
      rank_r      <= '0;
      tgt_hi_r    <= '0;
      tgt_mid_r   <= '0;
      tgt_lo_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      empty_r     <= empty_nxt;
      rank_r      <= rank_nxt;
      tgt_hi_r    <= tgt_hi_nxt;
      tgt_mid_r   <= tgt_mid_nxt;
      tgt_lo_r    <= tgt_lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_ent_r   <= out_ent_nxt;
    out_rank_r  <= out_rank_nxt;
    out_final_r <= out_final_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_node.valid        = out_valid_r;
  assign out_node.node_handle  = out_ent_r.handle;
  assign out_node.node_id_hi   = out_ent_r.id[ID_BITS-1 -: ID_HI_W];
  assign out_node.node_id_mid  = out_ent_r.id[ID_LO_W +: ID_MID_W];
  assign out_node.node_id_lo   = out_ent_r.id[ID_LO_W-1:0];
  assign out_node.rank         = RANK_W'(out_rank_r);
  assign out_node.final_of_run = out_final_r;
  assign out_node.list_empty   = out_empty_r;

endmodule

[design/xcns_cell.sv]
// One list slot: holds an entry and compares it against the candidate.
`timescale 1ns / 1ps
module xcns_cell import xcns_pkg::*; (
  input  logic               clk,
  input  entry_t             cand,
  input  logic [ID_BITS-1:0] target,
  input  entry_t             left_entry,
  input  entry_t             right_entry,
  input  cell_ctrl_t         ctrl,
  output entry_t             entry,
  output logic               id_equal,
  output logic               cand_nearer
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry       = entry_r;
  assign id_equal    = (cand.id == entry_r.id);
  assign cand_nearer = ((cand.id ^ target) < (entry_r.id ^ target));

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load_cand) begin
      entry_nxt = cand;
    end else if (ctrl.load_left) begin
      entry_nxt = left_entry;
    end else if (ctrl.shift_out) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the XOR closest-node selector: predicted node lists vs. DUT results.
`timescale 1ns / 1ps
module testbench;
  import xcns_pkg::*;

  localparam int CLK_HALF_NS   = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 64;
  localparam longint TIMEOUT_NS = 5_000_000;
  // unmapped register index, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct {
    logic [HANDLE_BITS-1:0] handle;
    logic [ID_BITS-1:0]     id;
    logic                   last;
  } candidate_t;

  typedef struct {
    logic [HANDLE_BITS-1:0] handle;
    logic [ID_BITS-1:0]     id;
    logic [RANK_W-1:0]      rank;
    logic                   final_of_run;
    logic                   list_empty;
  } node_result_t;

  typedef enum {PACE_STEADY, PACE_RANDOM, PACE_SPARSE, PACE_TOGGLE} pace_t;

  logic clk;
  logic rst_n;

  xcns_cand_if cand_bus ();
  xcns_node_if node_bus ();
  xcns_cfg_if  cfg_bus ();

  xor_closest_node_selector_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cand  (cand_bus),
    .out_node (node_bus),
    .cfg_wr   (cfg_bus)
  );

  candidate_t   cand_pending[$];
  node_result_t node_expected[$];

  // predicted selector state
  logic [ID_BITS-1:0]     sel_target = '0;
  logic [HANDLE_BITS-1:0] sel_handle[LIST_CAPACITY];
  logic [ID_BITS-1:0]     sel_id[LIST_CAPACITY];
  int                     sel_count = 0;

  bit cand_fire = 1'b0;
  bit cfg_fire  = 1'b0;
  int cands_queued = 0;
  int cands_taken = 0;
  int queries_done = 0;
  int results_checked = 0;
  int targets_loaded = 0;
  int fail_count = 0;

  int    send_burst = 0;
  int    send_gap = 0;
  pace_t pace = PACE_STEADY;
  int    pace_left = 0;
  int    hold_left = 0;
  bit    hold_request = 1'b0;
  bit    hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("xor_closest_node_selector_core: mismatch");
    $finish;
  end

  // Sorted insert by XOR distance; on the last candidate the list drains nearest first.
  function automatic void select_candidate(candidate_t c);
    int n;
    int pos;
    int i;
    bit dup;
    node_result_t r;
    n = sel_count;
    pos = n;
    dup = 1'b0;
    for (i = 0; i < n; i++) begin
      if (sel_id[i] == c.id) begin
        dup = 1'b1;
        break;
      end
      if ((c.id ^ sel_target) < (sel_id[i] ^ sel_target)) begin
        pos = i;
        break;
      end
    end
    if (!dup && pos < LIST_CAPACITY) begin
      if (n < LIST_CAPACITY) n++;
      for (i = n - 1; i > pos; i--) begin
        sel_handle[i] = sel_handle[i-1];
        sel_id[i] = sel_id[i-1];
      end
      sel_handle[pos] = c.handle;
      sel_id[pos] = c.id;
      sel_count = n;
    end
    if (c.last) begin
      if (sel_count == 0) begin
        r.handle = '0;
        r.id = '0;
        r.rank = '0;
        r.final_of_run = 1'b1;
        r.list_empty = 1'b1;
        node_expected.push_back(r);
      end
      for (i = 0; i < sel_count; i++) begin
        r.handle = sel_handle[i];
        r.id = sel_id[i];
        r.rank = RANK_W'(i);
        r.final_of_run = (i == sel_count - 1);
        r.list_empty = 1'b0;
        node_expected.push_back(r);
      end
      sel_count = 0;
    end
  endfunction

  function automatic void check_field(string name, logic [ID_BITS-1:0] want,
                                      logic [ID_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // monitor: results are checked first, then the accepted candidate is predicted
  always @(posedge clk) begin
    node_result_t want;
    candidate_t seen;
    cand_fire <= rst_n && cand_bus.valid && cand_bus.ready;
    cfg_fire  <= rst_n && cfg_bus.valid && cfg_bus.ready;
    if (rst_n && node_bus.valid && node_bus.ready) begin
      if (node_expected.size() == 0) begin
        $error("node result with none expected: handle 0x%0h rank %0d",
               node_bus.node_handle, node_bus.rank);
        fail_count++;
      end else begin
        want = node_expected.pop_front();
        check_field("node_handle", ID_BITS'(want.handle), ID_BITS'(node_bus.node_handle));
        check_field("node_id_hi", ID_BITS'(want.id[ID_BITS-1 -: ID_HI_W]),
                    ID_BITS'(node_bus.node_id_hi));
        check_field("node_id_mid", ID_BITS'(want.id[ID_LO_W +: ID_MID_W]),
                    ID_BITS'(node_bus.node_id_mid));
        check_field("node_id_lo", ID_BITS'(want.id[ID_LO_W-1:0]),
                    ID_BITS'(node_bus.node_id_lo));
        check_field("rank", ID_BITS'(want.rank), ID_BITS'(node_bus.rank));
        check_field("final_of_run", ID_BITS'(want.final_of_run),
                    ID_BITS'(node_bus.final_of_run));
        check_field("list_empty", ID_BITS'(want.list_empty), ID_BITS'(node_bus.list_empty));
        results_checked++;
      end
    end
    if (rst_n && cand_bus.valid && cand_bus.ready) begin
      seen.handle = cand_bus.cand_handle;
      seen.id = {cand_bus.cand_id_hi, cand_bus.cand_id_mid, cand_bus.cand_id_lo};
      seen.last = cand_bus.last_candidate;
      select_candidate(seen);
      cands_taken++;
      if (seen.last) queries_done++;
    end
    if (rst_n && cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        CFG_TARGET_HI:  sel_target[ID_BITS-1 -: ID_HI_W] = cfg_bus.data[ID_HI_W-1:0];
        CFG_TARGET_MID: sel_target[ID_LO_W +: ID_MID_W] = cfg_bus.data;
        CFG_TARGET_LO:  sel_target[ID_LO_W-1:0] = cfg_bus.data;
        default: ;
      endcase
    end
  end

  // candidate driver: bursts of random length separated by random gaps
  always @(negedge clk) begin
    candidate_t nxt;
    if (!rst_n) begin
      cand_bus.valid <= 1'b0;
      cand_bus.cand_handle <= '0;
      cand_bus.cand_id_hi <= '0;
      cand_bus.cand_id_mid <= '0;
      cand_bus.cand_id_lo <= '0;
      cand_bus.last_candidate <= 1'b0;
    end else if (!cand_bus.valid || cand_fire) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        cand_bus.valid <= 1'b0;
      end else if (cand_pending.size() > 0) begin
        nxt = cand_pending.pop_front();
        cand_bus.valid <= 1'b1;
        cand_bus.cand_handle <= nxt.handle;
        cand_bus.cand_id_hi <= nxt.id[ID_BITS-1 -: ID_HI_W];
        cand_bus.cand_id_mid <= nxt.id[ID_LO_W +: ID_MID_W];
        cand_bus.cand_id_lo <= nxt.id[ID_LO_W-1:0];
        cand_bus.last_candidate <= nxt.last;
        if (send_burst <= 1) begin
          send_burst <= $urandom_range(1, 40);
          send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          send_burst <= send_burst - 1;
        end
      end else begin
        cand_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver: its own stall pattern plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      node_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      node_bus.ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      node_bus.ready <= 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace_left <= $urandom_range(10, 120);
        pace <= pace_t'($urandom_range(0, 3));
      end else begin
        pace_left <= pace_left - 1;
      end
      case (pace)
        PACE_STEADY: node_bus.ready <= 1'b1;
        PACE_RANDOM: node_bus.ready <= 1'($urandom_range(0, 1));
        PACE_SPARSE: node_bus.ready <= ($urandom_range(0, 3) == 0);
        default:     node_bus.ready <= !node_bus.ready;
      endcase
    end
  end

  function automatic logic [ID_BITS-1:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic void queue_cand(logic [HANDLE_BITS-1:0] handle,
                                     logic [ID_BITS-1:0] id, logic last);
    candidate_t c;
    c.handle = handle;
    c.id = id;
    c.last = last;
    cand_pending.push_back(c);
    cands_queued++;
  endfunction

  // One query: ids spread between far away, near the target and repeats.
  // A few queries are noise with stray last flags.
  function automatic int queue_query(logic [ID_BITS-1:0] tgt);
    int len;
    int k;
    int kind;
    bit noise;
    logic [ID_BITS-1:0] id;
    logic [ID_BITS-1:0] prev;
    noise = ($urandom_range(0, 6) == 0);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 10);
    prev = tgt;
    for (k = 0; k < len; k++) begin
      kind = noise ? 0 : $urandom_range(0, 9);
      id = rand_id();
      case (kind)
        3, 4: id[ID_BITS-1:ID_LO_W] = tgt[ID_BITS-1:ID_LO_W];
        5:    id[ID_BITS-1 -: ID_HI_W] = tgt[ID_BITS-1 -: ID_HI_W];
        6: begin
          id = tgt;
          id[$urandom_range(0, ID_BITS-1)] ^= 1'b1;
        end
        7:    id = prev;
        8:    id = tgt ^ ID_BITS'($urandom_range(0, 15));
        9:    id[ID_LO_W-1:0] = tgt[ID_LO_W-1:0];
        default: ;
      endcase
      queue_cand(HANDLE_BITS'($urandom_range(0, 65535)), id,
                 (k == len - 1) || (noise && $urandom_range(0, 3) == 0));
      prev = id;
    end
    return len;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (cands_taken != cands_queued || node_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(negedge clk);
    while (!cfg_fire);
  endtask

  task automatic load_target(logic [ID_BITS-1:0] t, bit spare_write);
    // upper data bits of the hi register are don't-care, keep them noisy
    write_reg(CFG_TARGET_HI, {$urandom, t[ID_BITS-1 -: ID_HI_W]});
    write_reg(CFG_TARGET_MID, t[ID_LO_W +: ID_MID_W]);
    write_reg(CFG_TARGET_LO, t[ID_LO_W-1:0]);
    if (spare_write) write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
    cfg_bus.valid <= 1'b0;
    targets_loaded++;
  endtask

  initial begin
    logic [ID_BITS-1:0] tgt;
    int p;
    int queued;
    rst_n = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_TARGET_HI;
    cfg_bus.data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // target at reset value zero: single-entry list, then overflow with repeats
    queue_cand(16'h0000, '0, 1'b1);
    queue_cand(16'hFFFF, '1, 1'b0);
    queue_cand(16'h0001, {32'h0, 64'h0, 64'h1}, 1'b0);
    queue_cand(16'h0002, {32'h0, 64'h1, 64'h0}, 1'b0);
    queue_cand(16'h0003, {32'h1, 64'h0, 64'h0}, 1'b0);
    queue_cand(16'h0004, {32'h0, 64'h0, 64'h1}, 1'b0);
    queue_cand(16'h0005, {32'h0, 64'h0, {64{1'b1}}}, 1'b0);
    queue_cand(16'h0006, {32'h0, {64{1'b1}}, 64'h0}, 1'b0);
    queue_cand(16'h0007, {32'hFFFF_FFFF, 64'h0, 64'h0}, 1'b0);
    queue_cand(16'h0008, {32'h0, 64'h0, 64'h2}, 1'b0);
    queue_cand(16'h0009, {32'h0, 64'h0, 64'h3}, 1'b0);
    queue_cand(16'h000A, '1, 1'b0);
    queue_cand(16'h000B, {32'h0, 64'h0, 64'h2}, 1'b1);
    wait_idle();

    // target all ones, plus a write to the unmapped index
    tgt = '1;
    load_target(tgt, 1'b1);
    queue_cand(16'hFFFF, '1, 1'b0);
    queue_cand(16'h0000, '0, 1'b0);
    queue_cand(16'h5555, {32'hFFFF_FFFF, {64{1'b1}}, 64'hFFFF_FFFF_FFFF_FFFE}, 1'b0);
    queue_cand(16'hAAAA, {32'h7FFF_FFFF, {64{1'b1}}, {64{1'b1}}}, 1'b0);
    queue_cand(16'h1234, {32'hFFFF_FFFF, 64'h0, {64{1'b1}}}, 1'b1);
    wait_idle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1:       tgt = '0;
        3:       tgt = '1;
        default: tgt = rand_id();
      endcase
      load_target(tgt, p == 4);
      // long receiver hold-off while candidates keep coming
      if (p == 1) hold_request <= 1'b1;
      queued = 0;
      while (queued < PHASE_ITEMS) queued += queue_query(tgt);
      wait_idle();
    end

    $display("Covered %0d candidates in %0d queries over %0d target settings;",
             cands_taken, queries_done, targets_loaded);
    $display("%0d node results checked.", results_checked);
    if (fail_count == 0) begin
      $display("xor_closest_node_selector_core: match");
    end else begin
      $display("xor_closest_node_selector_core: mismatch");
    end
    $finish;
  end

endmodule
